// File: design/scm_pkg.sv
// ----------------------------------------------------------------------------
// scm_pkg: shared types and constants for the stereo crossfeed mixer
// Sample, coefficient and state widths, payload structs, register indexes and
// the command word passed from the sequencer to the datapath.
// ----------------------------------------------------------------------------
package scm_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 22;
    localparam int STATE_BITS     = 48;

    localparam int REG_BITS       = 24;
    localparam int GAIN_FRAC_BITS = 23;
    localparam int NUM_REGS       = 8;
    localparam int CFG_IDX_W      = $clog2(NUM_REGS);

    // shared multiplier operand and product widths
    localparam int OPD_W  = ((SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS) + 1;
    localparam int PROD_W = 2 * OPD_W;
    // filter add/subtract width, before saturation to the state width
    localparam int SUM_W  = ((PROD_W > STATE_BITS) ? PROD_W : STATE_BITS) + 1;
    // mix accumulator width
    localparam int ACC_W  = PROD_W + 1;

    localparam logic [REG_BITS-1:0] GAIN_ONE = REG_BITS'(1) << GAIN_FRAC_BITS;

    // sequencer length: sixteen products plus the steps that drain them
    localparam int NUM_STEPS = 18;
    localparam int STEP_W    = $clog2(NUM_STEPS);

    // filter slots
    localparam logic [1:0] FILT_LP_A = 2'd0;   // lowpass of B into output A
    localparam logic [1:0] FILT_HP_A = 2'd1;   // highpass of A into output A
    localparam logic [1:0] FILT_LP_B = 2'd2;   // lowpass of A into output B
    localparam logic [1:0] FILT_HP_B = 2'd3;   // highpass of B into output B

    localparam logic CHAN_A = 1'b0;
    localparam logic CHAN_B = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LP_B0  = 3'd0,
        CFG_LP_B1  = 3'd1,
        CFG_LP_A1  = 3'd2,
        CFG_HP_B0  = 3'd3,
        CFG_HP_B1  = 3'd4,
        CFG_HP_A1  = 3'd5,
        CFG_GAIN_D = 3'd6,
        CFG_GAIN_C = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        CS_B0,
        CS_B1,
        CS_A1,
        CS_GD,
        CS_GC
    } coef_sel_t;

    typedef enum logic [1:0] {
        DS_X,
        DS_YS,
        DS_XMIX,
        DS_SUM
    } dat_sel_t;

    typedef enum logic [2:0] {
        PO_NONE,
        PO_Y,
        PO_HOLD,
        PO_ZUPD,
        PO_ACC_LOAD,
        PO_ACC_ADD
    } post_op_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] chan_a_in;
        logic signed [SAMPLE_BITS-1:0] chan_b_in;
        logic                          block_end;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] chan_a_out;
        logic signed [SAMPLE_BITS-1:0] chan_b_out;
        logic                          block_end_out;
    } out_item_t;

    typedef struct packed {
        logic      in_load;
        coef_sel_t coef_sel;
        dat_sel_t  dat_sel;
        logic [1:0] mul_filt;
        logic      mix_chan;
        post_op_t  post_op;
        logic [1:0] post_filt;
        logic      round_en;
        logic [1:0] round_filt;
        logic      sum_en;
        logic      res_a_en;
        logic      out_load;
    } cmd_t;

endpackage

// File: design/stereo_crossfeed_mixer.sv
// ----------------------------------------------------------------------------
// stereo_crossfeed_mixer: first-order headphone crossfeed on stereo frames
// Output: the result is registered in the final schedule step, which waits
//   while a previous result is still pending. Frames are accepted only when
//   idle or in that final step; sixteen products share one 25x25 multiplier.
// Reset: synchronous active-low; clears filter state, loads register defaults
//   (unity direct gain, all else zero) and drops any pending result.
// ----------------------------------------------------------------------------
module stereo_crossfeed_mixer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [scm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [scm_pkg::REG_BITS-1:0]  cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  scm_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output scm_pkg::out_item_t            m_data
);

    scm_pkg::cmd_t cmd;

    scm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    scm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .m_data    (m_data)
    );

endmodule

// File: design/scm_ctrl.sv
// ----------------------------------------------------------------------------
// scm_ctrl: frame sequencer
// Runs the fixed eighteen-step schedule for one frame, drives the datapath
// command word and owns both handshakes.
// ----------------------------------------------------------------------------
module scm_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output scm_pkg::cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    localparam logic [scm_pkg::STEP_W-1:0] LAST_STEP = scm_pkg::STEP_W'(scm_pkg::NUM_STEPS - 1);

    state_t                     state_reg, state_next;
    logic [scm_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       m_valid_reg, m_valid_next;
    logic                       at_last;
    logic                       out_free;
    logic                       accept;
    scm_pkg::cmd_t              sched;

    assign at_last  = (state_reg == ST_RUN) && (step_reg == LAST_STEP);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) || (at_last && out_free);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    // schedule: one product issued per step up to step fifteen, its post-operation a step later
    always_comb begin
        sched            = '0;
        sched.coef_sel   = scm_pkg::CS_B0;
        sched.dat_sel    = scm_pkg::DS_X;
        sched.post_op    = scm_pkg::PO_NONE;
        case (step_reg)
            scm_pkg::STEP_W'(0): begin
                sched.mul_filt = scm_pkg::FILT_LP_A;
            end
            scm_pkg::STEP_W'(1): begin
                sched.mul_filt  = scm_pkg::FILT_HP_A;
                sched.post_op   = scm_pkg::PO_Y;
                sched.post_filt = scm_pkg::FILT_LP_A;
            end
            scm_pkg::STEP_W'(2): begin
                sched.mul_filt   = scm_pkg::FILT_LP_B;
                sched.post_op    = scm_pkg::PO_Y;
                sched.post_filt  = scm_pkg::FILT_HP_A;
                sched.round_en   = 1'b1;
                sched.round_filt = scm_pkg::FILT_LP_A;
            end
            scm_pkg::STEP_W'(3): begin
                sched.mul_filt   = scm_pkg::FILT_HP_B;
                sched.post_op    = scm_pkg::PO_Y;
                sched.post_filt  = scm_pkg::FILT_LP_B;
                sched.round_en   = 1'b1;
                sched.round_filt = scm_pkg::FILT_HP_A;
            end
            scm_pkg::STEP_W'(4): begin
                sched.coef_sel   = scm_pkg::CS_B1;
                sched.mul_filt   = scm_pkg::FILT_LP_A;
                sched.post_op    = scm_pkg::PO_Y;
                sched.post_filt  = scm_pkg::FILT_HP_B;
                sched.round_en   = 1'b1;
                sched.round_filt = scm_pkg::FILT_LP_B;
            end
            scm_pkg::STEP_W'(5): begin
                sched.coef_sel   = scm_pkg::CS_A1;
                sched.dat_sel    = scm_pkg::DS_YS;
                sched.mul_filt   = scm_pkg::FILT_LP_A;
                sched.post_op    = scm_pkg::PO_HOLD;
                sched.round_en   = 1'b1;
                sched.round_filt = scm_pkg::FILT_HP_B;
            end
            scm_pkg::STEP_W'(6): begin
                sched.coef_sel  = scm_pkg::CS_B1;
                sched.mul_filt  = scm_pkg::FILT_HP_A;
                sched.post_op   = scm_pkg::PO_ZUPD;
                sched.post_filt = scm_pkg::FILT_LP_A;
                sched.sum_en    = 1'b1;
            end
            scm_pkg::STEP_W'(7): begin
                sched.coef_sel = scm_pkg::CS_A1;
                sched.dat_sel  = scm_pkg::DS_YS;
                sched.mul_filt = scm_pkg::FILT_HP_A;
                sched.post_op  = scm_pkg::PO_HOLD;
            end
            scm_pkg::STEP_W'(8): begin
                sched.coef_sel  = scm_pkg::CS_B1;
                sched.mul_filt  = scm_pkg::FILT_LP_B;
                sched.post_op   = scm_pkg::PO_ZUPD;
                sched.post_filt = scm_pkg::FILT_HP_A;
            end
            scm_pkg::STEP_W'(9): begin
                sched.coef_sel = scm_pkg::CS_A1;
                sched.dat_sel  = scm_pkg::DS_YS;
                sched.mul_filt = scm_pkg::FILT_LP_B;
                sched.post_op  = scm_pkg::PO_HOLD;
            end
            scm_pkg::STEP_W'(10): begin
                sched.coef_sel  = scm_pkg::CS_B1;
                sched.mul_filt  = scm_pkg::FILT_HP_B;
                sched.post_op   = scm_pkg::PO_ZUPD;
                sched.post_filt = scm_pkg::FILT_LP_B;
            end
            scm_pkg::STEP_W'(11): begin
                sched.coef_sel = scm_pkg::CS_A1;
                sched.dat_sel  = scm_pkg::DS_YS;
                sched.mul_filt = scm_pkg::FILT_HP_B;
                sched.post_op  = scm_pkg::PO_HOLD;
            end
            scm_pkg::STEP_W'(12): begin
                sched.coef_sel  = scm_pkg::CS_GD;
                sched.dat_sel   = scm_pkg::DS_XMIX;
                sched.mix_chan  = scm_pkg::CHAN_A;
                sched.post_op   = scm_pkg::PO_ZUPD;
                sched.post_filt = scm_pkg::FILT_HP_B;
            end
            scm_pkg::STEP_W'(13): begin
                sched.coef_sel = scm_pkg::CS_GC;
                sched.dat_sel  = scm_pkg::DS_SUM;
                sched.mix_chan = scm_pkg::CHAN_A;
                sched.post_op  = scm_pkg::PO_ACC_LOAD;
            end
            scm_pkg::STEP_W'(14): begin
                sched.coef_sel = scm_pkg::CS_GD;
                sched.dat_sel  = scm_pkg::DS_XMIX;
                sched.mix_chan = scm_pkg::CHAN_B;
                sched.post_op  = scm_pkg::PO_ACC_ADD;
            end
            scm_pkg::STEP_W'(15): begin
                sched.coef_sel = scm_pkg::CS_GC;
                sched.dat_sel  = scm_pkg::DS_SUM;
                sched.mix_chan = scm_pkg::CHAN_B;
                sched.post_op  = scm_pkg::PO_ACC_LOAD;
                sched.res_a_en = 1'b1;
            end
            scm_pkg::STEP_W'(16): begin
                sched.post_op = scm_pkg::PO_ACC_ADD;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        cmd          = sched;
        cmd.in_load  = accept;
        cmd.out_load = at_last && out_free;
        if (state_reg != ST_RUN) begin
            cmd.post_op  = scm_pkg::PO_NONE;
            cmd.round_en = 1'b0;
            cmd.sum_en   = 1'b0;
            cmd.res_a_en = 1'b0;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN: begin
                if (step_reg != LAST_STEP) begin
                    step_next = step_reg + 1'b1;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    step_next    = '0;
                    state_next   = accept ? ST_RUN : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_RUN && step_reg == '0))
        else $error("accepted frame did not start the schedule at step zero");

    a_step_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && step_reg != LAST_STEP)
            |=> (state_reg == ST_RUN && step_reg == scm_pkg::STEP_W'($past(step_reg) + 1'b1)))
        else $error("schedule step skipped or stalled mid-frame");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (!$past(m_valid_reg) && m_valid_reg) |-> $past(at_last))
        else $error("result raised outside the final step");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (at_last && m_valid_reg && !m_ready) |=> (at_last && m_valid_reg))
        else $error("final step left while the previous result was still pending");

endmodule

// File: design/scm_datapath.sv
// ----------------------------------------------------------------------------
// scm_datapath: filter and mix arithmetic
// Configuration registers, frame registers, one shared signed multiplier with
// registered product, filter state, saturating post-operations and the
// output register.
// ----------------------------------------------------------------------------
module scm_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [scm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scm_pkg::REG_BITS-1:0]    cfg_wdata,
    input  scm_pkg::in_item_t               s_data,
    input  scm_pkg::cmd_t                   cmd,
    output scm_pkg::out_item_t              m_data
);

    localparam int SB     = scm_pkg::SAMPLE_BITS;
    localparam int RB     = scm_pkg::REG_BITS;
    localparam int OW     = scm_pkg::OPD_W;
    localparam int PW     = scm_pkg::PROD_W;
    localparam int SW     = scm_pkg::SUM_W;
    localparam int ZW     = scm_pkg::STATE_BITS;
    localparam int AW     = scm_pkg::ACC_W;
    localparam int RY_W   = ZW + 1;
    localparam int RM_W   = AW + 1;
    localparam int CF     = scm_pkg::COEF_FRAC_BITS;
    localparam int GF     = scm_pkg::GAIN_FRAC_BITS;

    localparam logic signed [ZW-1:0]   Z_MAX  = {1'b0, {(ZW-1){1'b1}}};
    localparam logic signed [ZW-1:0]   Z_MIN  = {1'b1, {(ZW-1){1'b0}}};
    localparam logic signed [SB-1:0]   S_MAX  = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0]   S_MIN  = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [RY_W-1:0] Y_HALF = RY_W'(1) << (CF - 1);
    localparam logic signed [RM_W-1:0] M_HALF = RM_W'(1) << (GF - 1);

    // configuration
    logic signed [RB-1:0] lp_b0_reg, lp_b1_reg, lp_a1_reg;
    logic signed [RB-1:0] hp_b0_reg, hp_b1_reg, hp_a1_reg;
    logic        [RB-1:0] gain_d_reg, gain_c_reg;

    // frame
    logic signed [SB-1:0] x_a_reg, x_b_reg;
    logic                 blk_end_reg;

    // working state
    logic signed [PW-1:0]   prod_reg;
    logic signed [PW-1:0]   hold_reg;
    logic signed [ZW-1:0]   y_reg;
    logic signed [ZW-1:0]   z_reg [4];
    logic signed [SB-1:0]   ys_reg [4];
    logic signed [SB:0]     sum_a_reg, sum_b_reg;
    logic signed [AW-1:0]   acc_reg;
    logic signed [SB-1:0]   res_a_reg;
    scm_pkg::out_item_t     out_reg;

    logic                 use_lp;
    logic signed [RB-1:0] coef_b0, coef_b1, coef_a1;
    logic signed [SB-1:0] x_filt;
    logic signed [OW-1:0] opd_a, opd_b;
    logic signed [SW-1:0] y_sum, z_diff;
    logic signed [ZW-1:0] y_sat, z_sat;
    logic signed [RY_W-1:0] y_rnd;
    logic signed [SB-1:0]   ys_sat;
    logic signed [RM_W-1:0] m_rnd;
    logic signed [SB-1:0]   mix_sat;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lp_b0_reg  <= '0;
            lp_b1_reg  <= '0;
            lp_a1_reg  <= '0;
            hp_b0_reg  <= '0;
            hp_b1_reg  <= '0;
            hp_a1_reg  <= '0;
            gain_d_reg <= scm_pkg::GAIN_ONE;
            gain_c_reg <= '0;
        end else if (cfg_wr_en) begin
            case (scm_pkg::cfg_idx_t'(cfg_index))
                scm_pkg::CFG_LP_B0:  lp_b0_reg  <= $signed(cfg_wdata);
                scm_pkg::CFG_LP_B1:  lp_b1_reg  <= $signed(cfg_wdata);
                scm_pkg::CFG_LP_A1:  lp_a1_reg  <= $signed(cfg_wdata);
                scm_pkg::CFG_HP_B0:  hp_b0_reg  <= $signed(cfg_wdata);
                scm_pkg::CFG_HP_B1:  hp_b1_reg  <= $signed(cfg_wdata);
                scm_pkg::CFG_HP_A1:  hp_a1_reg  <= $signed(cfg_wdata);
                scm_pkg::CFG_GAIN_D: gain_d_reg <= cfg_wdata;
                scm_pkg::CFG_GAIN_C: gain_c_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            x_a_reg     <= s_data.chan_a_in;
            x_b_reg     <= s_data.chan_b_in;
            blk_end_reg <= s_data.block_end;
        end
    end

    // operand selection: lowpass slots are even, highpass slots odd
    assign use_lp  = !cmd.mul_filt[0];
    assign coef_b0 = use_lp ? lp_b0_reg : hp_b0_reg;
    assign coef_b1 = use_lp ? lp_b1_reg : hp_b1_reg;
    assign coef_a1 = use_lp ? lp_a1_reg : hp_a1_reg;
    // highpass A and lowpass B take A; lowpass A and highpass B take B
    assign x_filt  = (cmd.mul_filt[0] ^ cmd.mul_filt[1]) ? x_a_reg : x_b_reg;

    always_comb begin
        case (cmd.coef_sel)
            scm_pkg::CS_B0: opd_a = OW'(coef_b0);
            scm_pkg::CS_B1: opd_a = OW'(coef_b1);
            scm_pkg::CS_A1: opd_a = OW'(coef_a1);
            scm_pkg::CS_GD: opd_a = $signed(OW'(gain_d_reg));
            scm_pkg::CS_GC: opd_a = $signed(OW'(gain_c_reg));
            default:        opd_a = '0;
        endcase
    end

    always_comb begin
        case (cmd.dat_sel)
            scm_pkg::DS_X:    opd_b = OW'(x_filt);
            scm_pkg::DS_YS:   opd_b = OW'(ys_reg[cmd.mul_filt]);
            scm_pkg::DS_XMIX: opd_b = (cmd.mix_chan == scm_pkg::CHAN_B) ? OW'(x_b_reg)
                                                                         : OW'(x_a_reg);
            scm_pkg::DS_SUM:  opd_b = (cmd.mix_chan == scm_pkg::CHAN_B) ? OW'(sum_b_reg)
                                                                         : OW'(sum_a_reg);
            default:          opd_b = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= opd_a * opd_b;
    end

    // y = b0*x + z, and z' = b1*x - a1*ys, both saturated to the state width
    assign y_sum  = SW'(prod_reg) + SW'(z_reg[cmd.post_filt]);
    assign z_diff = SW'(hold_reg) - SW'(prod_reg);

    always_comb begin
        if (&y_sum[SW-1:ZW-1] || ~|y_sum[SW-1:ZW-1]) begin
            y_sat = y_sum[ZW-1:0];
        end else begin
            y_sat = y_sum[SW-1] ? Z_MIN : Z_MAX;
        end
        if (&z_diff[SW-1:ZW-1] || ~|z_diff[SW-1:ZW-1]) begin
            z_sat = z_diff[ZW-1:0];
        end else begin
            z_sat = z_diff[SW-1] ? Z_MIN : Z_MAX;
        end
    end

    // filter output: round half up, drop the coefficient fraction, saturate
    assign y_rnd = (RY_W'(y_reg) + Y_HALF) >>> CF;

    always_comb begin
        if (&y_rnd[RY_W-1:SB-1] || ~|y_rnd[RY_W-1:SB-1]) begin
            ys_sat = y_rnd[SB-1:0];
        end else begin
            ys_sat = y_rnd[RY_W-1] ? S_MIN : S_MAX;
        end
    end

    // mix output: round half up, drop the gain fraction, saturate
    assign m_rnd = (RM_W'(acc_reg) + M_HALF) >>> GF;

    always_comb begin
        if (&m_rnd[RM_W-1:SB-1] || ~|m_rnd[RM_W-1:SB-1]) begin
            mix_sat = m_rnd[SB-1:0];
        end else begin
            mix_sat = m_rnd[RM_W-1] ? S_MIN : S_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                z_reg[i] <= '0;
            end
        end else if (cmd.post_op == scm_pkg::PO_ZUPD) begin
            z_reg[cmd.post_filt] <= z_sat;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.post_op)
            scm_pkg::PO_Y:        y_reg    <= y_sat;
            scm_pkg::PO_HOLD:     hold_reg <= prod_reg;
            scm_pkg::PO_ACC_LOAD: acc_reg  <= AW'(prod_reg);
            scm_pkg::PO_ACC_ADD:  acc_reg  <= acc_reg + AW'(prod_reg);
            default: begin
            end
        endcase
        if (cmd.round_en) begin
            ys_reg[cmd.round_filt] <= ys_sat;
        end
        if (cmd.sum_en) begin
            sum_a_reg <= (SB+1)'(ys_reg[scm_pkg::FILT_LP_A]) + (SB+1)'(ys_reg[scm_pkg::FILT_HP_A]);
            sum_b_reg <= (SB+1)'(ys_reg[scm_pkg::FILT_LP_B]) + (SB+1)'(ys_reg[scm_pkg::FILT_HP_B]);
        end
        if (cmd.res_a_en) begin
            res_a_reg <= mix_sat;
        end
        if (cmd.out_load) begin
            out_reg.chan_a_out    <= res_a_reg;
            out_reg.chan_b_out    <= mix_sat;
            out_reg.block_end_out <= blk_end_reg;
        end
    end

    assign m_data = out_reg;

endmodule
